@@ src/btpc_pkg.sv @@
package btpc_pkg;

	localparam int unsigned CfgWidth = 48;
	localparam int unsigned CfgIdxWidth = 3;

	localparam logic [CfgIdxWidth-1:0] REG_AC_SIGNED   = 3'd0;
	localparam logic [CfgIdxWidth-1:0] REG_AC_UNSIGNED = 3'd1;
	localparam logic [CfgIdxWidth-1:0] REG_B_PAIR      = 3'd2;
	localparam logic [CfgIdxWidth-1:0] REG_M_PAIR      = 3'd3;
	localparam logic [CfgIdxWidth-1:0] REG_OVERSAMPLING = 3'd4;

	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] B7_SCALE = 32'd50000;
	localparam logic [31:0] P_C1 = 32'd3038;
	localparam logic [31:0] P_C2 = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_C3 = 32'd3791;
	localparam logic [31:0] X3_BIAS = 32'd32768;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_X1,
		ST_T_DEN,
		ST_T_DIV,
		ST_T_FIN,
		ST_P_SQ,
		ST_P_X1A,
		ST_P_X2A,
		ST_P_B3,
		ST_P_X1B,
		ST_P_X2B,
		ST_P_B4,
		ST_P_B7,
		ST_P_DIV,
		ST_P_PQ,
		ST_P_Y1,
		ST_P_Y2,
		ST_P_Y3,
		ST_P_Y4,
		ST_P_FIN,
		ST_OUT
	} state_t;

	// 32x32 product, low word
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

@@ src/baro_temp_pressure_compensation_unit.sv @@
// One word in flight: a temperature or pressure word is accepted only while idle, and the
// next word is taken only after the result has been taken and the unit is idle again.
// A single 32x32 multiplier and a radix-2 divider do the arithmetic; a zero divisor
// skips the division and offers a zero result with divide_error set.
// Reset clears configuration registers, stored B5 and control state to zero.
module baro_temp_pressure_compensation_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [btpc_pkg::CfgIdxWidth-1:0] cfg_index,
	input  logic [btpc_pkg::CfgWidth-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [23:0]                     raw_reading,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            result_kind,
	output logic signed [31:0]              result_value,
	output logic                            divide_error
);
	import btpc_pkg::*;

	logic [47:0] ac_s_q, ac_u_q;
	logic [31:0] b_pair_q, m_pair_q;
	logic [1:0]  oss_q;
	logic [31:0] b5_q;

	state_t state_q, state_d;
	logic        kind_q, err_q;
	logic [23:0] raw_q;
	logic [31:0] val_q;
	// working registers
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	// shared multiplier operands
	logic [31:0] mop_a, mop_b, mprod;
	assign mprod = mul32(mop_a, mop_b);

	// divider: unsigned restoring, one bit per cycle
	logic        div_go;
	logic [31:0] div_n, div_d;
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0]  dcnt_q;
	logic        dbusy_q;
	logic [32:0] dtrial;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (div_go) begin
			dbusy_q <= 1'b1;
			dcnt_q <= 6'd32;
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q - 6'd1;
			if (dcnt_q == 6'd1)
				dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			dq_q <= div_n;
			dd_q <= div_d;
			dr_q <= '0;
		end else if (dbusy_q) begin
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= {dr_q[30:0], dq_q[31]};
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_s_q <= '0;
			ac_u_q <= '0;
			b_pair_q <= '0;
			m_pair_q <= '0;
			oss_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AC_SIGNED:    ac_s_q <= cfg_data;
				REG_AC_UNSIGNED:  ac_u_q <= cfg_data;
				REG_B_PAIR:       b_pair_q <= cfg_data[31:0];
				REG_M_PAIR:       m_pair_q <= cfg_data[31:0];
				REG_OVERSAMPLING: oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(ac_s_q[47:32]);
	assign ac2 = sx16(ac_s_q[31:16]);
	assign ac3 = sx16(ac_s_q[15:0]);
	assign ac4 = {16'd0, ac_u_q[47:32]};
	assign ac5 = {16'd0, ac_u_q[31:16]};
	assign ac6 = {16'd0, ac_u_q[15:0]};
	assign b1 = sx16(b_pair_q[31:16]);
	assign b2 = sx16(b_pair_q[15:0]);
	assign mc = sx16(m_pair_q[31:16]);
	assign md = sx16(m_pair_q[15:0]);

	logic [31:0] b6, up, scale, b3pre, b3, dnum, sgn_num, sgn_den;
	assign b6 = b5_q - B6_OFFSET;
	assign up = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
	assign scale = B7_SCALE >> oss_q;
	// a_q holds x3 here; b3 = trunc((((ac1*4+x3)<<oss)+2)/4)
	assign b3pre = ((ac1 << 2) + a_q << oss_q) + 32'd2;
	assign b3 = b3pre[31] ? 32'(0 - ((32'(0) - b3pre) >> 2)) : (b3pre >> 2);
	assign dnum = m_pair_q[31:16] == 16'd0 ? 32'd0 : (mc << 11);
	assign sgn_num = dnum[31] ? 32'(0) - dnum : dnum;
	assign sgn_den = b_q[31] ? 32'(0) - b_q : b_q;

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		mop_a = '0;
		mop_b = '0;
		div_go = 1'b0;
		div_n = '0;
		div_d = '0;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = mode ? ST_P_SQ : ST_T_X1;
			ST_T_X1: begin
				mop_a = {16'd0, raw_q[15:0]} - ac6;
				mop_b = ac5;
				state_d = ST_T_DEN;
			end
			ST_T_DEN: state_d = (b_q == 32'd0) ? ST_OUT : ST_T_DIV;
			ST_T_DIV: begin
				div_go = (c_q == 32'd0);
				div_n = sgn_num;
				div_d = sgn_den;
				if (c_q != 32'd0 && !dbusy_q) state_d = ST_T_FIN;
			end
			ST_T_FIN: state_d = ST_OUT;
			ST_P_SQ: begin
				mop_a = b6; mop_b = b6; state_d = ST_P_X1A;
			end
			ST_P_X1A: begin
				mop_a = b2; mop_b = c_q; state_d = ST_P_X2A;
			end
			ST_P_X2A: begin
				mop_a = ac2; mop_b = b6; state_d = ST_P_B3;
			end
			ST_P_B3: state_d = ST_P_X1B;
			ST_P_X1B: begin
				mop_a = ac3; mop_b = b6; state_d = ST_P_X2B;
			end
			ST_P_X2B: begin
				mop_a = b1; mop_b = c_q; state_d = ST_P_B4;
			end
			ST_P_B4: begin
				mop_a = ac4; mop_b = asr32(a_q + d_q + 32'd2, 5'd2) + X3_BIAS;
				state_d = ST_P_B7;
			end
			ST_P_B7: begin
				mop_a = up - e_q; mop_b = scale;
				state_d = (b_q == 32'd0) ? ST_OUT : ST_P_DIV;
			end
			ST_P_DIV: begin
				div_go = (d_q == 32'd0);
				div_n = a_q[31] ? a_q : {a_q[30:0], 1'b0};
				div_d = b_q;
				if (d_q != 32'd0 && !dbusy_q) state_d = ST_P_PQ;
			end
			ST_P_PQ: state_d = ST_P_Y1;
			ST_P_Y1: begin
				mop_a = asr32(c_q, 5'd8); mop_b = asr32(c_q, 5'd8); state_d = ST_P_Y2;
			end
			ST_P_Y2: begin
				mop_a = a_q; mop_b = P_C1; state_d = ST_P_Y3;
			end
			ST_P_Y3: begin
				mop_a = P_C2; mop_b = c_q; state_d = ST_P_Y4;
			end
			ST_P_Y4: state_d = ST_P_FIN;
			ST_P_FIN: state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			b5_q <= '0;
			err_q <= 1'b0;
			kind_q <= 1'b0;
			val_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					kind_q <= mode;
					err_q <= 1'b0;
					val_q <= '0;
				end
				ST_T_DEN: if (b_q == 32'd0) err_q <= 1'b1;
				ST_T_FIN: begin
					b5_q <= a_q + d_q;
					val_q <= asr32(a_q + d_q + 32'd8, 5'd4);
				end
				ST_P_B7: if (b_q == 32'd0) err_q <= 1'b1;
				ST_P_FIN: val_q <= c_q + asr32(a_q + e_q + P_C3, 5'd4);
				default: ;
			endcase
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				raw_q <= raw_reading;
				c_q <= '0;
				d_q <= '0;
			end
			ST_T_X1: begin
				a_q <= asr32(mprod, 5'd15);
				b_q <= asr32(mprod, 5'd15) + md;
			end
			ST_T_DIV: begin
				c_q <= 32'd1;
				if (c_q != 32'd0 && !dbusy_q)
					d_q <= (dnum[31] != b_q[31]) ? 32'(0) - dq_q : dq_q;
			end
			ST_P_SQ: c_q <= asr32(mprod, 5'd12);
			ST_P_X1A: a_q <= asr32(mprod, 5'd11);
			ST_P_X2A: a_q <= a_q + asr32(mprod, 5'd11);
			ST_P_B3: e_q <= b3;
			ST_P_X1B: a_q <= asr32(mprod, 5'd13);
			ST_P_X2B: d_q <= asr32(mprod, 5'd16);
			ST_P_B4: begin
				b_q <= mprod >> 15;
				d_q <= '0;
			end
			ST_P_B7: a_q <= mprod;
			ST_P_DIV: if (d_q == 32'd0) d_q <= 32'd1;
			ST_P_PQ: c_q <= a_q[31] ? {dq_q[30:0], 1'b0} : dq_q;
			ST_P_Y1: a_q <= mprod;
			ST_P_Y2: a_q <= asr32(mprod, 5'd16);
			ST_P_Y3: e_q <= asr32(mprod, 5'd16);
			default: ;
		endcase
	end

	assign out_valid = (state_q == ST_OUT);
	assign result_kind = kind_q;
	assign result_value = err_q ? 32'sd0 : $signed(val_q);
	assign divide_error = err_q;

	ap_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_value)))
		else $error("result dropped under stall");
	ap_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_error) |-> (result_value == 32'sd0))
		else $error("error with nonzero value");
	ap_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !dbusy_q)
		else $error("divider busy while idle");

endmodule

@@ dv/baro_temp_pressure_compensation_unit_tb.sv @@
module baro_temp_pressure_compensation_unit_tb;
	import btpc_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [23:0] raw;
	} reading_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic        err;
	} comp_t;

	localparam int IdlePct = 26;
	localparam int HoldCycles = 400;
	localparam int WatchdogLimit = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [CfgWidth-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [23:0] raw_reading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic signed [31:0] result_value;
	logic divide_error;

	reading_t pending_readings[$];
	comp_t expected_results[$];
	int errors = 0;
	int stalled_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// predictor copies of the calibration and stored B5
	logic [47:0] m_ac_s, m_ac_u;
	logic [31:0] m_b_pair, m_m_pair, m_b5;
	logic [1:0] m_oss;

	baro_temp_pressure_compensation_unit i_dut (.*);

	always #4 clk = ~clk;

	function automatic logic [31:0] shr_arith(input logic [31:0] x, input int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// truncating signed division, wraps on the most negative quotient
	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic comp_t compensate(input reading_t rd);
		comp_t r;
		logic [31:0] ut, x1, x2, x3, den, b6, sq, b3, b4, b7, up, p, t;
		r.kind = rd.mode;
		r.value = '0;
		r.err = 1'b0;
		if (!rd.mode) begin
			ut = {16'd0, rd.raw[15:0]};
			x1 = shr_arith((ut - {16'd0, m_ac_u[15:0]}) * {16'd0, m_ac_u[31:16]}, 15);
			den = x1 + ext16(m_m_pair[15:0]);
			if (den == 0) begin
				r.err = 1'b1;
			end else begin
				x2 = div_trunc(ext16(m_m_pair[31:16]) << 11, den);
				m_b5 = x1 + x2;
				r.value = shr_arith(m_b5 + 32'd8, 4);
			end
		end else begin
			up = {8'd0, rd.raw} >> (8 - m_oss);
			b6 = m_b5 - 32'd4000;
			sq = shr_arith(b6 * b6, 12);
			x1 = shr_arith(ext16(m_b_pair[15:0]) * sq, 11);
			x2 = shr_arith(ext16(m_ac_s[31:16]) * b6, 11);
			x3 = x1 + x2;
			t = ((ext16(m_ac_s[47:32]) * 32'd4 + x3) << m_oss) + 32'd2;
			b3 = div_trunc(t, 32'd4);
			x1 = shr_arith(ext16(m_ac_s[15:0]) * b6, 13);
			x2 = shr_arith(ext16(m_b_pair[31:16]) * sq, 16);
			x3 = shr_arith(x1 + x2 + 32'd2, 2);
			b4 = ({16'd0, m_ac_u[47:32]} * (x3 + 32'd32768)) >> 15;
			b7 = (up - b3) * (32'd50000 >> m_oss);
			if (b4 == 0) begin
				r.err = 1'b1;
			end else begin
				if (!b7[31])
					p = (b7 * 32'd2) / b4;
				else
					p = (b7 / b4) * 32'd2;
				x1 = shr_arith(p, 8);
				x1 = x1 * x1;
				x1 = shr_arith(x1 * 32'd3038, 16);
				x2 = shr_arith(32'hFFFF_E343 * p, 16);
				r.value = p + shr_arith(x1 + x2 + 32'd3791, 4);
			end
		end
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < IdlePct);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(compensate('{mode, raw_reading}));
			if (!in_valid || !in_stall) begin
				if (pending_readings.size() > 0 && !idle_now()) begin
					reading_t rd;
					rd = pending_readings.pop_front();
					in_valid <= 1'b1;
					mode <= rd.mode;
					raw_reading <= rd.raw;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: kind %0d value %0d", result_kind,
						result_value);
					errors++;
				end else begin
					comp_t e;
					e = expected_results.pop_front();
					if (result_kind !== e.kind) begin
						$error("result_kind: expected %0d actual %0d", e.kind, result_kind);
						errors++;
					end
					if (result_value !== e.value) begin
						$error("result_value: expected %0d actual %0d", $signed(e.value),
							result_value);
						errors++;
					end
					if (divide_error !== e.err) begin
						$error("divide_error: expected %0d actual %0d", e.err, divide_error);
						errors++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HoldCycles;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_now();
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stalled_cycles <= 0;
		else if (arst_n)
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WatchdogLimit) begin
			$display("baro_temp_pressure_compensation_unit test failed");
			$finish;
		end
	end

	task automatic wait_drained();
		wait (pending_readings.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [47:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_AC_SIGNED:    m_ac_s = data;
			REG_AC_UNSIGNED:  m_ac_u = data;
			REG_B_PAIR:       m_b_pair = data[31:0];
			REG_M_PAIR:       m_m_pair = data[31:0];
			REG_OVERSAMPLING: m_oss = data[1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_cal(input logic [47:0] acs, input logic [47:0] acu,
		input logic [31:0] bp, input logic [31:0] mp, input logic [1:0] oss);
		wait_drained();
		// upper bits of the narrow registers are junk on purpose
		write_reg(REG_AC_SIGNED, acs);
		write_reg(REG_AC_UNSIGNED, acu);
		write_reg(REG_B_PAIR, {16'($urandom), bp});
		write_reg(REG_M_PAIR, {16'($urandom), mp});
		write_reg(REG_OVERSAMPLING, {46'($urandom), oss});
	endtask

	task automatic add_reading(input logic md, input logic [23:0] raw);
		pending_readings.push_back('{md, raw});
	endtask

	task automatic add_random(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 80) begin
				// temperature then pressure, as a host would sequence them
				if ($urandom_range(0, 1))
					add_reading(1'b0, {8'($urandom), 16'($urandom_range(20000, 40000))});
				else
					add_reading(1'b0, 24'($urandom));
				if ($urandom_range(0, 1))
					add_reading(1'b1, 24'($urandom_range(24'h4F0000, 24'hB00000)));
				else
					add_reading(1'b1, 24'($urandom));
				k++;
			end else begin
				add_reading(1'($urandom), 24'($urandom));
			end
		end
	endtask

	task automatic random_cal(input logic [1:0] oss);
		load_cal({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
			32'($urandom), 32'($urandom), oss);
	endtask

	initial begin
		m_ac_s = '0;
		m_ac_u = '0;
		m_b_pair = '0;
		m_m_pair = '0;
		m_oss = '0;
		m_b5 = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: every divisor is zero, pressure before any temperature
		add_reading(1'b1, 24'h5D2300);
		add_reading(1'b0, 24'h006CFA);
		add_reading(1'b1, 24'hFFFFFF);
		add_reading(1'b0, 24'h000000);

		// datasheet example calibration
		load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd0);
		add_reading(1'b0, 24'd27898);
		add_reading(1'b1, 24'd23843 << 8);
		add_reading(1'b0, 24'h000000);
		add_reading(1'b1, 24'h000000);
		add_reading(1'b0, 24'h00FFFF);
		add_reading(1'b1, 24'hFFFFFF);
		add_reading(1'b0, 24'hFF6CFA); // high byte must be ignored
		add_reading(1'b1, 24'h5D2300);
		hold_req = 1'b1;
		add_random(200);
		for (int o = 1; o < 4; o++) begin
			load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd32757, 16'd23153},
				{16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'(o));
			add_reading(1'b0, 24'd27898);
			add_reading(1'b1, 24'hFFFFFF);
			add_random(180);
		end

		// all ones
		load_cal('1, '1, '1, '1, 2'd3);
		add_reading(1'b0, 24'hFFFFFF);
		add_reading(1'b1, 24'hFFFFFF);
		add_reading(1'b1, 24'h000000);
		add_random(150);

		// AC5 zero: temperature divisor is MD alone; AC4 zero: pressure divisor zero
		load_cal({16'h8000, 16'h7FFF, 16'h8000}, {16'd0, 16'd0, 16'hFFFF}, {16'h7FFF, 16'h8000},
			{16'h8000, 16'd0}, 2'd2);
		add_reading(1'b0, 24'd27898);
		add_reading(1'b1, 24'h800000);
		add_random(100);

		for (int ph = 0; ph < 4; ph++) begin
			random_cal(2'(ph));
			calm = (ph == 1);
			add_random(170);
		end
		calm = 1'b0;
		random_cal(2'($urandom));
		add_random(220);

		wait_drained();
		if (errors == 0)
			$display("baro_temp_pressure_compensation_unit test passed");
		else
			$display("baro_temp_pressure_compensation_unit test failed");
		$finish;
	end

endmodule
